>>> sv/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

    // Initial chaining vector A, B, C, D
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    // First padding byte
    localparam logic [31:0] PAD_BYTE = 32'h00000080;

    // Fill level at which the bit length is appended
    localparam logic [5:0] LEN_FILL = 6'd56;

    localparam logic [5:0] LAST_ROUND = 6'd63;

    // Additive constant of each round
    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amount, indexed by {round group, round low bits}
    localparam logic [4:0] ROUND_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_PAD80,
        ST_PADZ,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // Chaining words, [0] is A
    typedef logic [3:0][31:0] chain_t;

    // Byte-granular write into one buffer word
    typedef struct packed {
        logic        en;
        logic [3:0]  idx;
        logic [1:0]  off;
        logic [2:0]  cnt;
        logic [31:0] data;
    } buf_wr_t;

    // Control of the shared round unit
    typedef struct packed {
        logic       start;
        logic       step;
        logic [5:0] rnd;
    } round_ctl_t;

    // Message word used by a round
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] rl;
        logic [3:0] w;
        rl = r[3:0];
        unique case (r[5:4])
            2'd0: w = rl;
            2'd1: w = 4'd1 + (rl << 2) + rl;
            2'd2: w = 4'd5 + (rl << 1) + rl;
            2'd3: w = (rl << 3) - rl;
        endcase
        return w;
    endfunction

endpackage

>>> sv/md5_round_unit.sv
// ----------------------------------------------------------------------------
// md5_round_unit
// Working registers A..D and the one MD5 round that updates them per cycle while ctl.step is set.
// ----------------------------------------------------------------------------
module md5_round_unit (
    input  logic                clk,
    input  md5_pkg::round_ctl_t ctl,
    input  md5_pkg::chain_t     chain,
    input  logic [31:0]         msg_word,
    output md5_pkg::chain_t     work
);

    md5_pkg::chain_t work_reg;
    md5_pkg::chain_t work_next;
    logic [31:0]     f_val;
    logic [31:0]     sum;
    logic [63:0]     dbl;
    logic [4:0]      shamt;

    // Round function, rotate and add
    always_comb
    begin
        unique case (ctl.rnd[5:4])
            2'd0: f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            2'd1: f_val = (work_reg[1] & work_reg[3]) | (work_reg[2] & ~work_reg[3]);
            2'd2: f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            2'd3: f_val = work_reg[2] ^ (work_reg[1] | ~work_reg[3]);
        endcase
        sum   = work_reg[0] + f_val + msg_word + md5_pkg::ROUND_K[ctl.rnd];
        shamt = md5_pkg::ROUND_S[{ctl.rnd[5:4], ctl.rnd[1:0]}];
        dbl   = {sum, sum} << shamt;

        work_next = work_reg;
        if (ctl.start)
        begin
            work_next = chain;
        end
        else if (ctl.step)
        begin
            work_next[0] = work_reg[3];
            work_next[1] = work_reg[1] + dbl[63:32];
            work_next[2] = work_reg[1];
            work_next[3] = work_reg[2];
        end
    end

    // Hold the working words
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign work = work_reg;

endmodule

>>> sv/md5_block_buf.sv
// ----------------------------------------------------------------------------
// md5_block_buf
// Sixteen-word block buffer with byte-lane writes and one registered read port.
// ----------------------------------------------------------------------------
module md5_block_buf (
    input  logic             clk,
    input  md5_pkg::buf_wr_t wr,
    input  logic [3:0]       rd_idx,
    output logic [31:0]      rd_data
);

    logic [31:0] words_reg [16];
    logic [31:0] rd_data_reg;
    logic [31:0] shifted;
    logic [3:0]  lane_en;

    // Align the bytes to their lanes and mark the lanes written
    always_comb
    begin
        shifted = wr.data << {wr.off, 3'b000};
        for (int j = 0; j < 4; j++)
        begin
            lane_en[j] = wr.en && (3'(j) >= {1'b0, wr.off})
                         && (3'(j) < ({1'b0, wr.off} + wr.cnt));
        end
    end

    // Write the selected lanes
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (lane_en[j])
            begin
                words_reg[wr.idx][8*j +: 8] <= shifted[8*j +: 8];
            end
        end
    end

    // Read one word, available the cycle after the address
    always_ff @(posedge clk)
    begin
        rd_data_reg <= words_reg[rd_idx];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/md5_digest_out.sv
// ----------------------------------------------------------------------------
// md5_digest_out
// Holds a finished digest and streams it out as four words.
// ----------------------------------------------------------------------------
module md5_digest_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  md5_pkg::chain_t digest,
    output logic            busy,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata,   // digest_word[31:0]
    output logic [1:0]      m_tuser,   // word_index[1:0]
    output logic            m_tlast
);

    md5_pkg::chain_t words_reg;
    logic [1:0]      idx_reg;
    logic            busy_reg;

    // Capture the digest
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            words_reg <= digest;
        end
    end

    // Advance through the four words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (busy_reg && m_tready)
        begin
            if (idx_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    assign busy     = busy_reg;
    assign m_tvalid = busy_reg;
    assign m_tdata  = words_reg[idx_reg];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == 2'd3);

endmodule

>>> sv/md5_digest_engine_unit.sv
// ----------------------------------------------------------------------------
// md5_digest_engine_unit
// MD5 digest of a byte message streamed in as little-endian 32-bit words.
// ----------------------------------------------------------------------------
// Input channel s_*: one item carries up to four message bytes (first byte in
// bits 7:0) and a byte count; s_tlast marks the final item of a message, an
// empty message being a single last item with count zero. Output channel m_*:
// four items per message, chaining words A..D, with m_tlast on D.
// Each item is accepted while the sequencer is idle and then written to the
// buffer, in two writes when it straddles a word boundary of the buffer. Each
// full block then runs the shared round unit, one round per cycle: 64 rounds
// and then a fold into the chaining words. After a last item, padding takes
// 3 to 18 buffer writes and one or two further compressions; after the final
// fold, the emit state hands the digest to the output registers, which then
// raise m_tvalid.
// The finished digest moves to an output register set, so the next message is
// taken while the receiver drains it; a second digest waits for that set to
// be free. s_tready is high only while the sequencer is idle.
// Reset restores the initial vector and clears fill level and length; the
// block buffer holds no reset value since every byte is written before use.
// ----------------------------------------------------------------------------
module md5_digest_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // data_word[31:0], valid_bytes[34:32], zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // digest_word[31:0]
    output logic [1:0]  m_tuser,    // word_index[1:0]
    output logic        m_tlast
);

    md5_pkg::state_t     state_reg, state_next;
    md5_pkg::state_t     ret_reg, ret_next;
    md5_pkg::state_t     after;
    logic [31:0]         data_reg, data_next;
    logic [2:0]          rem_reg, rem_next;
    logic                last_reg, last_next;
    logic [5:0]          fill_reg, fill_next;
    logic [60:0]         len_reg, len_next;
    md5_pkg::chain_t     chain_reg, chain_next;
    logic [5:0]          rnd_reg, rnd_next;

    md5_pkg::buf_wr_t    buf_wr;
    md5_pkg::round_ctl_t rctl;
    md5_pkg::chain_t     work;
    logic [31:0]         msg_word;
    logic                out_load;
    logic                out_busy;

    logic [2:0]          nb;
    logic [2:0]          room;
    logic [2:0]          n_abs;
    logic [6:0]          fill_sum;
    logic [63:0]         bit_len;

    md5_pkg::chain_t     iv;

    assign iv      = {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
    assign nb      = s_tdata[34] ? 3'd4 : s_tdata[34:32];
    assign room    = 3'd4 - {1'b0, fill_reg[1:0]};
    assign n_abs   = (rem_reg < room) ? rem_reg : room;
    assign bit_len = {len_reg, 3'b000};

    // Sequencer: next state, buffer writes and round control
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        data_next  = data_reg;
        rem_next   = rem_reg;
        last_next  = last_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        chain_next = chain_reg;
        rnd_next   = rnd_reg;
        after      = state_reg;
        buf_wr     = '0;
        rctl       = '0;
        rctl.rnd   = rnd_reg;
        out_load   = 1'b0;
        s_tready   = 1'b0;

        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    data_next = s_tdata[31:0];
                    rem_next  = nb;
                    last_next = s_tlast;
                    len_next  = len_reg + {58'd0, nb};
                    if (nb != 3'd0)
                    begin
                        state_next = md5_pkg::ST_ABSORB;
                    end
                    else if (s_tlast)
                    begin
                        state_next = md5_pkg::ST_PAD80;
                    end
                end
            end
            md5_pkg::ST_ABSORB:
            begin
                buf_wr.en   = 1'b1;
                buf_wr.idx  = fill_reg[5:2];
                buf_wr.off  = fill_reg[1:0];
                buf_wr.cnt  = n_abs;
                buf_wr.data = data_reg;
                rem_next    = rem_reg - n_abs;
                data_next   = data_reg >> {n_abs, 3'b000};
                if (rem_reg != n_abs)
                begin
                    after = md5_pkg::ST_ABSORB;
                end
                else if (last_reg)
                begin
                    after = md5_pkg::ST_PAD80;
                end
                else
                begin
                    after = md5_pkg::ST_IDLE;
                end
            end
            md5_pkg::ST_PAD80:
            begin
                buf_wr.en   = 1'b1;
                buf_wr.idx  = fill_reg[5:2];
                buf_wr.off  = fill_reg[1:0];
                buf_wr.cnt  = room;
                buf_wr.data = md5_pkg::PAD_BYTE;
                after       = md5_pkg::ST_PADZ;
            end
            md5_pkg::ST_PADZ:
            begin
                if (fill_reg == md5_pkg::LEN_FILL)
                begin
                    state_next = md5_pkg::ST_LEN_LO;
                end
                else
                begin
                    buf_wr.en   = 1'b1;
                    buf_wr.idx  = fill_reg[5:2];
                    buf_wr.cnt  = 3'd4;
                    after       = md5_pkg::ST_PADZ;
                end
            end
            md5_pkg::ST_LEN_LO:
            begin
                buf_wr.en   = 1'b1;
                buf_wr.idx  = fill_reg[5:2];
                buf_wr.cnt  = 3'd4;
                buf_wr.data = bit_len[31:0];
                after       = md5_pkg::ST_LEN_HI;
            end
            md5_pkg::ST_LEN_HI:
            begin
                buf_wr.en   = 1'b1;
                buf_wr.idx  = fill_reg[5:2];
                buf_wr.cnt  = 3'd4;
                buf_wr.data = bit_len[63:32];
                after       = md5_pkg::ST_EMIT;
            end
            md5_pkg::ST_ROUND:
            begin
                rctl.step = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == md5_pkg::LAST_ROUND)
                begin
                    state_next = md5_pkg::ST_FOLD;
                end
            end
            md5_pkg::ST_FOLD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_next[i] = chain_reg[i] + work[i];
                end
                state_next = ret_reg;
            end
            md5_pkg::ST_EMIT:
            begin
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    chain_next = iv;
                    len_next   = '0;
                    fill_next  = '0;
                    state_next = md5_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase

        // Advance the fill level; a full block starts the compression
        fill_sum = {1'b0, fill_reg} + {4'd0, buf_wr.cnt};
        if (buf_wr.en)
        begin
            fill_next = fill_sum[5:0];
            if (fill_sum[6])
            begin
                state_next = md5_pkg::ST_ROUND;
                ret_next   = after;
                rctl.start = 1'b1;
                rnd_next   = '0;
            end
            else
            begin
                state_next = after;
            end
        end
    end

    // Control and chaining registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= md5_pkg::ST_IDLE;
            ret_reg   <= md5_pkg::ST_IDLE;
            rem_reg   <= '0;
            last_reg  <= 1'b0;
            fill_reg  <= '0;
            len_reg   <= '0;
            chain_reg <= {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            rem_reg   <= rem_next;
            last_reg  <= last_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            chain_reg <= chain_next;
            rnd_reg   <= rnd_next;
        end
    end

    // Hold the item's remaining bytes
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Fetch the message word of the coming round in the cycle before it runs
    md5_block_buf u_buf (
        .clk     (clk),
        .wr      (buf_wr),
        .rd_idx  (md5_pkg::msg_index(rnd_next)),
        .rd_data (msg_word)
    );

    md5_round_unit u_round (
        .clk      (clk),
        .ctl      (rctl),
        .chain    (chain_reg),
        .msg_word (msg_word),
        .work     (work)
    );

    md5_digest_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .digest   (chain_reg),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Rounds run back to back without a gap
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md5_pkg::ST_ROUND && rnd_reg != md5_pkg::LAST_ROUND)
        |=> (state_reg == md5_pkg::ST_ROUND && rnd_reg == $past(rnd_reg) + 6'd1))
        else $error("round counter skipped");

    // The buffer is stable while a block is compressed
    a_no_write_in_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md5_pkg::ST_ROUND || state_reg == md5_pkg::ST_FOLD)
        |-> !buf_wr.en)
        else $error("buffer written during compression");

    // A digest never overwrites one still being sent
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_busy && !m_tvalid))
        else $error("digest loaded while output busy");

    // Zero padding and length run on word-aligned fill levels
    a_pad_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md5_pkg::ST_PADZ || state_reg == md5_pkg::ST_LEN_LO
         || state_reg == md5_pkg::ST_LEN_HI) |-> (fill_reg[1:0] == 2'd0))
        else $error("padding on unaligned fill level");

endmodule
